// File: hdl/sdsq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdsq_pkg
// Shared types, codes and helpers for the SD SPI-mode command sequencer.
// ----------------------------------------------------------------------------
package sdsq_pkg;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 56;
   localparam int RSP_QUEUE_DEPTH = 4;

   localparam logic [15:0] DEFAULT_TIMEOUT_RESET = 16'd1000;
   localparam logic [7:0] IDLE_BYTE = 8'hFF;
   localparam logic [7:0] CMD_START_BITS = 8'h40;
   localparam logic [5:0] CMD_MASK = 6'h3F;
   localparam logic [7:0] CRC_CMD0 = 8'h95;
   localparam logic [7:0] CRC_CMD8 = 8'h87;
   localparam logic [7:0] CRC_OTHER = 8'h01;
   localparam logic [5:0] CMD_GO_IDLE = 6'd0;
   localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
   localparam logic [4:0] FRAME_BYTES = 5'd6;

   typedef enum logic [1:0] {
      ACT_START = 2'd0,
      ACT_RX_BYTE = 2'd1,
      ACT_TICK = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_EXCHANGE = 2'd0,
      KIND_WORD = 2'd1,
      KIND_FINISHED = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      RESP_NONE = 3'd0,
      RESP_R1 = 3'd1,
      RESP_R1B = 3'd2,
      RESP_R3_R7 = 3'd3,
      RESP_R2 = 3'd4
   } resp_kind_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_PRE,
      PH_FRAME,
      PH_POLL,
      PH_TICK,
      PH_READ
   } phase_type;

   typedef enum logic {
      STATUS_OK = 1'b0,
      STATUS_TIMEOUT = 1'b1
   } status_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] tx_byte;
      logic chip_select;
      logic [31:0] word_value;
      logic [1:0] word_index;
      logic status;
      logic [7:0] r1_value;
      logic last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic [7:0] frame_byte(input logic [2:0] idx, input logic [5:0] cmd,
                                             input logic [31:0] arg);
      logic [7:0] b;
      begin
         case (idx)
            3'd0: b = CMD_START_BITS | {2'b00, cmd & CMD_MASK};
            3'd1: b = arg[31:24];
            3'd2: b = arg[23:16];
            3'd3: b = arg[15:8];
            3'd4: b = arg[7:0];
            default: begin
               if (cmd == CMD_GO_IDLE) b = CRC_CMD0;
               else if (cmd == CMD_SEND_IF_COND) b = CRC_CMD8;
               else b = CRC_OTHER;
            end
         endcase
         return b;
      end
   endfunction

   function automatic result_type mk_exchange(input logic [7:0] tx, input logic cs,
                                              input logic last);
      result_type r;
      begin
         r = '0;
         r.kind = KIND_EXCHANGE;
         r.tx_byte = tx;
         r.chip_select = cs;
         r.last = last;
         return r;
      end
   endfunction

   function automatic result_type mk_word(input logic [31:0] value, input logic [1:0] idx);
      result_type r;
      begin
         r = '0;
         r.kind = KIND_WORD;
         r.chip_select = 1'b1;
         r.word_value = value;
         r.word_index = idx;
         return r;
      end
   endfunction

   function automatic result_type mk_finish(input logic status, input logic [7:0] r1);
      result_type r;
      begin
         r = '0;
         r.kind = KIND_FINISHED;
         r.status = status;
         r.r1_value = r1;
         r.last = 1'b1;
         return r;
      end
   endfunction

endpackage
`default_nettype wire

// File: hdl/sd_spi_command_sequencer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sd_spi_command_sequencer_core
// SD card SPI-mode command sequencer: frames a command, polls R1, reads
// R3/R7 and R2 payload words.
// ----------------------------------------------------------------------------
// One request is taken per clock while the result queue has room for two
// results; its results appear on rsp in the cycle after it is taken at the
// earliest. Most requests give one result; the byte that completes an R3/R7 or
// R2 word gives two, and the single-result output port gives them one at a
// time, so the output port sets the sustained rate. csr writes are taken every
// cycle outside reset; neither input channel is ready while reset is high.
module sd_spi_command_sequencer_core #(
   parameter int QUEUE_DEPTH = sdsq_pkg::RSP_QUEUE_DEPTH
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   // command_index, argument, response_kind, poll_limit, rx_byte, zero pad
   input wire logic [sdsq_pkg::REQ_TDATA_W-1:0] req_tdata,
   // action
   input wire logic [1:0] req_tuser,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   // tx_byte, chip_select, word_value, word_index, status, r1_value, zero pad
   output logic [sdsq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // kind
   output logic [1:0] rsp_tuser,
   output logic rsp_tlast,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [15:0] csr_data
);

   sdsq_pkg::push_type push;
   sdsq_pkg::result_type head;
   logic room;
   logic fire;
   logic csr_fire;

   assign req_tready = room && !reset;
   assign fire = req_tvalid && req_tready;
   assign csr_ready = !reset;
   assign csr_fire = csr_valid && csr_ready;

   sdsq_seq u_seq (
      .clock(clock),
      .reset(reset),
      .fire(fire),
      .action(req_tuser),
      .command_index(req_tdata[5:0]),
      .argument(req_tdata[37:6]),
      .response_kind(req_tdata[40:38]),
      .poll_limit(req_tdata[56:41]),
      .rx_byte(req_tdata[64:57]),
      .csr_write(csr_fire),
      .csr_value(csr_data),
      .push(push)
   );

   sdsq_rsp_fifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_rsp_fifo (
      .clock(clock),
      .reset(reset),
      .push(push),
      .room(room),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_item(head)
   );

   assign rsp_tdata = {4'b0000, head.r1_value, head.status, head.word_index,
                       head.word_value, head.chip_select, head.tx_byte};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule
`default_nettype wire

// File: hdl/sdsq_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdsq_seq
// Command state machine: one request in, up to two results out per cycle.
// ----------------------------------------------------------------------------
module sdsq_seq (
   input wire logic clock,
   input wire logic reset,
   input wire logic fire,
   input wire logic [1:0] action,
   input wire logic [5:0] command_index,
   input wire logic [31:0] argument,
   input wire logic [2:0] response_kind,
   input wire logic [15:0] poll_limit,
   input wire logic [7:0] rx_byte,
   input wire logic csr_write,
   input wire logic [15:0] csr_value,
   output sdsq_pkg::push_type push
);

   sdsq_pkg::phase_type phase_ff, phase_in;
   logic [4:0] byte_count_ff, byte_count_in;
   logic [5:0] command_ff, command_in;
   logic [31:0] argument_ff, argument_in;
   logic [2:0] resp_kind_ff, resp_kind_in;
   logic [15:0] polls_left_ff, polls_left_in;
   logic [31:0] word_shift_ff, word_shift_in;
   logic [7:0] resp_byte_ff, resp_byte_in;
   logic [1:0] word_count_ff, word_count_in;
   logic [15:0] default_timeout_ff;

   logic [31:0] shifted;
   logic [4:0] read_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sdsq_pkg::PH_IDLE;
         byte_count_ff <= '0;
         command_ff <= '0;
         argument_ff <= '0;
         resp_kind_ff <= '0;
         polls_left_ff <= '0;
         word_shift_ff <= '0;
         word_count_ff <= '0;
         resp_byte_ff <= sdsq_pkg::IDLE_BYTE;
         default_timeout_ff <= sdsq_pkg::DEFAULT_TIMEOUT_RESET;
      end else begin
         phase_ff <= phase_in;
         byte_count_ff <= byte_count_in;
         command_ff <= command_in;
         argument_ff <= argument_in;
         resp_kind_ff <= resp_kind_in;
         polls_left_ff <= polls_left_in;
         word_shift_ff <= word_shift_in;
         word_count_ff <= word_count_in;
         resp_byte_ff <= resp_byte_in;
         if (csr_write) default_timeout_ff <= csr_value;
      end
   end

   assign shifted = {word_shift_ff[23:0], rx_byte};
   assign read_count = byte_count_ff + 5'd1;

   always_comb begin
      phase_in = phase_ff;
      byte_count_in = byte_count_ff;
      command_in = command_ff;
      argument_in = argument_ff;
      resp_kind_in = resp_kind_ff;
      polls_left_in = polls_left_ff;
      word_shift_in = word_shift_ff;
      resp_byte_in = resp_byte_ff;
      word_count_in = word_count_ff;
      push = '0;
      if (fire) begin
         case (action)
            sdsq_pkg::ACT_START: begin
               command_in = command_index;
               argument_in = argument;
               resp_kind_in = response_kind;
               polls_left_in = (poll_limit != 16'd0) ? poll_limit : default_timeout_ff;
               byte_count_in = '0;
               word_shift_in = '0;
               word_count_in = '0;
               resp_byte_in = sdsq_pkg::IDLE_BYTE;
               phase_in = sdsq_pkg::PH_PRE;
               push.count = 2'd1;
               push.first = sdsq_pkg::mk_exchange(sdsq_pkg::IDLE_BYTE, 1'b0, 1'b1);
            end
            sdsq_pkg::ACT_TICK: begin
               if (phase_ff == sdsq_pkg::PH_TICK) begin
                  push.count = 2'd1;
                  if (polls_left_ff == 16'd0) begin
                     resp_byte_in = sdsq_pkg::IDLE_BYTE;
                     phase_in = sdsq_pkg::PH_IDLE;
                     push.first = sdsq_pkg::mk_finish(sdsq_pkg::STATUS_TIMEOUT,
                                                      sdsq_pkg::IDLE_BYTE);
                  end else begin
                     phase_in = sdsq_pkg::PH_POLL;
                     push.first = sdsq_pkg::mk_exchange(sdsq_pkg::IDLE_BYTE, 1'b1, 1'b1);
                  end
               end
            end
            sdsq_pkg::ACT_RX_BYTE: begin
               case (phase_ff)
                  sdsq_pkg::PH_PRE: begin
                     phase_in = sdsq_pkg::PH_FRAME;
                     byte_count_in = 5'd1;
                     push.count = 2'd1;
                     push.first = sdsq_pkg::mk_exchange(
                        sdsq_pkg::frame_byte(3'd0, command_ff, argument_ff), 1'b1, 1'b1);
                  end
                  sdsq_pkg::PH_FRAME: begin
                     push.count = 2'd1;
                     if (byte_count_ff < sdsq_pkg::FRAME_BYTES) begin
                        byte_count_in = read_count;
                        push.first = sdsq_pkg::mk_exchange(
                           sdsq_pkg::frame_byte(byte_count_ff[2:0], command_ff, argument_ff),
                           1'b1, 1'b1);
                     end else if (polls_left_ff == 16'd0) begin
                        resp_byte_in = sdsq_pkg::IDLE_BYTE;
                        phase_in = sdsq_pkg::PH_IDLE;
                        push.first = sdsq_pkg::mk_finish(sdsq_pkg::STATUS_TIMEOUT,
                                                         sdsq_pkg::IDLE_BYTE);
                     end else begin
                        phase_in = sdsq_pkg::PH_POLL;
                        push.first = sdsq_pkg::mk_exchange(sdsq_pkg::IDLE_BYTE, 1'b1, 1'b1);
                     end
                  end
                  sdsq_pkg::PH_POLL: begin
                     polls_left_in = polls_left_ff - 16'd1;
                     if (!rx_byte[7]) begin
                        resp_byte_in = rx_byte;
                        push.count = 2'd1;
                        if (resp_kind_ff == sdsq_pkg::RESP_R3_R7 ||
                            resp_kind_ff == sdsq_pkg::RESP_R2) begin
                           phase_in = sdsq_pkg::PH_READ;
                           byte_count_in = '0;
                           word_shift_in = '0;
                           word_count_in = (resp_kind_ff == sdsq_pkg::RESP_R2) ? 2'd3 : 2'd0;
                           push.first = sdsq_pkg::mk_exchange(sdsq_pkg::IDLE_BYTE, 1'b1,
                                                              1'b1);
                        end else begin
                           phase_in = sdsq_pkg::PH_IDLE;
                           push.first = sdsq_pkg::mk_finish(sdsq_pkg::STATUS_OK, rx_byte);
                        end
                     end else begin
                        phase_in = sdsq_pkg::PH_TICK;
                     end
                  end
                  sdsq_pkg::PH_READ: begin
                     word_shift_in = shifted;
                     byte_count_in = read_count;
                     if (read_count[1:0] != 2'd0) begin
                        push.count = 2'd1;
                        push.first = sdsq_pkg::mk_exchange(sdsq_pkg::IDLE_BYTE, 1'b1, 1'b1);
                     end else if (word_count_ff == 2'd0) begin
                        phase_in = sdsq_pkg::PH_IDLE;
                        push.count = 2'd2;
                        push.first = sdsq_pkg::mk_word(shifted, 2'd0);
                        push.second = sdsq_pkg::mk_finish(sdsq_pkg::STATUS_OK, resp_byte_ff);
                     end else begin
                        word_count_in = word_count_ff - 2'd1;
                        word_shift_in = '0;
                        push.count = 2'd2;
                        push.first = sdsq_pkg::mk_word(shifted, word_count_ff);
                        push.second = sdsq_pkg::mk_exchange(sdsq_pkg::IDLE_BYTE, 1'b1, 1'b1);
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_two_only_in_read: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> phase_ff == sdsq_pkg::PH_READ)
      else $error("two results outside response read");
   a_no_push_idle: assert property (@(posedge clock) disable iff (reset)
      !fire |-> push.count == 2'd0)
      else $error("results without a request");
   a_start_one_result: assert property (@(posedge clock) disable iff (reset)
      (fire && action == sdsq_pkg::ACT_START) |-> push.count == 2'd1)
      else $error("start without a single result");
`endif

endmodule
`default_nettype wire

// File: hdl/sdsq_rsp_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdsq_rsp_fifo
// Result queue taking up to two results a cycle and giving one a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module sdsq_rsp_fifo #(
   parameter int DEPTH = sdsq_pkg::RSP_QUEUE_DEPTH
) (
   input wire logic clock,
   input wire logic reset,
   input wire sdsq_pkg::push_type push,
   output logic room,
   output logic out_valid,
   input wire logic out_ready,
   output sdsq_pkg::result_type out_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - 2);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   sdsq_pkg::result_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_next;
   logic pop;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      begin
         return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
      end
   endfunction

   assign room = count_ff <= ROOM_LIMIT;
   assign out_valid = count_ff != '0;
   assign out_item = entry_ff[rd_ptr_ff];
   assign pop = out_valid && out_ready;
   assign wr_next = bump(wr_ptr_ff);

   always_comb begin
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      case (push.count)
         2'd1: wr_ptr_in = wr_next;
         2'd2: wr_ptr_in = bump(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2) entry_ff[wr_next] <= push.second;
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("result queue overflow");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room)
      else $error("push without room");
   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && push.count == 2'd0) |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("pop did not drain queue");
`endif

endmodule
`default_nettype wire
